// ===== src/ladsr_pkg.sv =====
// Package for the linear ADSR envelope block.
// Holds widths, Q1.23 constants, segment and register codes, shared structs.
// No dependencies.
package ladsr_pkg;

	localparam int INDEX_BITS = 24;
	localparam int DATA_W     = 24;
	localparam int SEG_W      = 3;
	localparam int CFG_IDX_W  = 3;
	// compare width: index or length plus headroom for the sum of three lengths
	localparam int CMP_W      = ((INDEX_BITS > DATA_W) ? INDEX_BITS : DATA_W) + 2;
	localparam int PROD_W     = 2 * DATA_W;

	localparam logic [DATA_W-1:0] ONE_Q23      = DATA_W'(8388608);
	localparam logic [DATA_W-1:0] FALLBACK_Q23 = DATA_W'(6710886);

	localparam logic [SEG_W-1:0] SEG_ATTACK   = 3'd0;
	localparam logic [SEG_W-1:0] SEG_DECAY    = 3'd1;
	localparam logic [SEG_W-1:0] SEG_SUSTAIN  = 3'd2;
	localparam logic [SEG_W-1:0] SEG_RELEASE  = 3'd3;
	localparam logic [SEG_W-1:0] SEG_FALLBACK = 3'd4;
	localparam logic [SEG_W-1:0] SEG_FINISHED = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] attack_len;
		logic [DATA_W-1:0] decay_len;
		logic [DATA_W-1:0] release_len;
		logic [DATA_W-1:0] total_len;
		logic [DATA_W-1:0] sustain_level;
		logic [DATA_W-1:0] attack_step;
		logic [DATA_W-1:0] decay_step;
		logic [DATA_W-1:0] release_step;
	} cfg_t;

	// work for the level stage: segment, multiplier operand, coefficient and last flag
	typedef struct packed {
		logic [SEG_W-1:0]  seg;
		logic [DATA_W-1:0] op;
		logic [DATA_W-1:0] coef;
		logic              last;
	} work_t;

endpackage

// ===== src/ladsr_seq.sv =====
// Sample index register and segment classification (first pipeline stage).
// Depends on ladsr_pkg.
module ladsr_seq import ladsr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  accept,
	input  logic  restart,
	input  logic  load_en,
	output logic  valid_s1,
	output work_t work_s1
);

	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] idx_cur;
	logic [INDEX_BITS-1:0] idx_next;
	logic [CMP_W-1:0]      i_x, a_x, d_x, r_x, t_x, adr_x, ad_x, tr_x;
	work_t                 work;

	always_comb begin
		idx_cur = restart ? '0 : idx_q;
		i_x     = CMP_W'(idx_cur);
		a_x     = CMP_W'(cfg.attack_len);
		d_x     = CMP_W'(cfg.decay_len);
		r_x     = CMP_W'(cfg.release_len);
		t_x     = CMP_W'(cfg.total_len);
		ad_x    = a_x + d_x;
		adr_x   = ad_x + r_x;
		tr_x    = t_x - r_x;

		work.seg  = SEG_FINISHED;
		work.op   = '0;
		work.coef = '0;
		work.last = 1'b0;
		idx_next  = idx_cur;

		if (i_x < t_x) begin
			work.last = (i_x == t_x - CMP_W'(1));
			idx_next  = (idx_cur == IDX_MAX) ? idx_cur : idx_cur + INDEX_BITS'(1);
			if (adr_x >= t_x) begin
				work.seg = SEG_FALLBACK;
			end else if (i_x < a_x) begin
				work.seg  = SEG_ATTACK;
				work.op   = i_x[DATA_W-1:0];
				work.coef = cfg.attack_step;
			end else if (i_x < ad_x) begin
				work.seg  = SEG_DECAY;
				work.op   = DATA_W'(i_x - a_x);
				work.coef = cfg.decay_step;
			end else if (i_x < tr_x) begin
				work.seg  = SEG_SUSTAIN;
				work.coef = cfg.sustain_level;
			end else begin
				work.seg  = SEG_RELEASE;
				work.op   = DATA_W'(t_x - i_x);
				work.coef = cfg.release_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= idx_next;
			end
			if (load_en) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work;
		end
	end

endmodule

// ===== src/ladsr_level.sv =====
// Level computation: one multiply with saturation, into the result register.
// Depends on ladsr_pkg.
module ladsr_level import ladsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_en,
	input  logic              valid_s1,
	input  work_t             work_s1,
	output logic              valid_s2,
	output logic [DATA_W-1:0] level_s2,
	output logic [SEG_W-1:0]  seg_s2,
	output logic              last_s2
);

	logic [PROD_W-1:0] prod;
	logic [DATA_W-1:0] level;

	always_comb begin
		prod = PROD_W'(work_s1.op) * PROD_W'(work_s1.coef);
		case (work_s1.seg)
			SEG_ATTACK, SEG_RELEASE: begin
				level = (prod > PROD_W'(ONE_Q23)) ? ONE_Q23 : prod[DATA_W-1:0];
			end
			SEG_DECAY: begin
				level = (prod >= PROD_W'(ONE_Q23)) ? '0 : ONE_Q23 - prod[DATA_W-1:0];
			end
			SEG_SUSTAIN: begin
				level = (work_s1.coef > ONE_Q23) ? ONE_Q23 : work_s1.coef;
			end
			SEG_FALLBACK: begin
				level = FALLBACK_Q23;
			end
			default: begin
				level = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && valid_s1) begin
			level_s2 <= level;
			seg_s2   <= work_s1.seg;
			last_s2  <= work_s1.last;
		end
	end

endmodule

// ===== src/linear_adsr_envelope.sv =====
// Linear ADSR envelope generator, top level.
// Configuration registers and pipeline control; uses ladsr_pkg, ladsr_seq, ladsr_level.
//
// Usage:
//   Each request on the input channel (in_valid, in_stall, restart) is one audio
//   sample tick and yields exactly one result on the output channel (out_valid,
//   out_stall, level, segment, last). An item moves when valid is high and stall
//   is low. restart = 1 zeroes the sample index before the tick is evaluated.
//   Pipeline: the accepting edge loads the index and segment stage; the multiply
//   and saturate stage then loads the result register once the receiver has room.
//   Throughput: one request per cycle; both stages advance together unless the
//   receiver stalls.
//   When the receiver stalls, the result register holds and the first stage
//   still takes one more request if it is empty; after that in_stall follows out_stall.
//   Configuration: write cfg_wdata to register cfg_idx when cfg_wen is high,
//   only while no request is in flight. No read-back.
//   Reset clears all configuration registers, the sample index and both pipeline valids;
//   with all lengths zero every tick reports the finished segment at level zero.
module linear_adsr_envelope import ladsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    level,
	output logic [SEG_W-1:0]     segment,
	output logic                 last
);

	cfg_t  cfg_q;
	logic  valid_s1;
	work_t work_s1;
	logic  load_s2;
	logic  load_s1;
	logic  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_ATTACK_LEN:    cfg_q.attack_len    <= cfg_wdata;
				REG_DECAY_LEN:     cfg_q.decay_len     <= cfg_wdata;
				REG_RELEASE_LEN:   cfg_q.release_len   <= cfg_wdata;
				REG_TOTAL_LEN:     cfg_q.total_len     <= cfg_wdata;
				REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_wdata;
				REG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_wdata;
				REG_DECAY_STEP:    cfg_q.decay_step    <= cfg_wdata;
				REG_RELEASE_STEP:  cfg_q.release_step  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// advance each stage when its successor has room
	assign load_s2  = !out_valid || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;
	assign accept   = in_valid && load_s1;

	ladsr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.restart  (restart),
		.load_en  (load_s1),
		.valid_s1 (valid_s1),
		.work_s1  (work_s1)
	);

	ladsr_level u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (load_s2),
		.valid_s1 (valid_s1),
		.work_s1  (work_s1),
		.valid_s2 (out_valid),
		.level_s2 (level),
		.seg_s2   (segment),
		.last_s2  (last)
	);

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= ONE_Q23)
		else $error("level above 1.0");

	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment == SEG_FINISHED |-> level == '0 && !last)
		else $error("finished result not zero");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_stall |=> out_valid)
		else $error("first stage request lost");

endmodule

// ===== tb/sv/ladsr_checker.sv =====
// Envelope checker: mirrors register writes, predicts one sample per accepted request
// and compares each accepted result in order. Depends on ladsr_pkg.
module ladsr_checker import ladsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 restart,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [DATA_W-1:0]    level,
	input  logic [SEG_W-1:0]     segment,
	input  logic                 last,
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0] level;
		logic [SEG_W-1:0]  segment;
		logic              last;
	} env_sample_t;

	env_sample_t             pending_samples[$];
	cfg_t                    shadow_regs;
	logic [INDEX_BITS-1:0]   note_pos;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("ERROR %0t ns: %s: expected %0d, got %0d", $realtime, what, want, got);
		errors++;
	endtask

	function automatic logic [DATA_W-1:0] clamp_one(input logic [63:0] v);
		return (v > 64'(ONE_Q23)) ? ONE_Q23 : DATA_W'(v);
	endfunction

	function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		case (idx)
			REG_ATTACK_LEN:    shadow_regs.attack_len = data;
			REG_DECAY_LEN:     shadow_regs.decay_len = data;
			REG_RELEASE_LEN:   shadow_regs.release_len = data;
			REG_TOTAL_LEN:     shadow_regs.total_len = data;
			REG_SUSTAIN_LEVEL: shadow_regs.sustain_level = data;
			REG_ATTACK_STEP:   shadow_regs.attack_step = data;
			REG_DECAY_STEP:    shadow_regs.decay_step = data;
			REG_RELEASE_STEP:  shadow_regs.release_step = data;
			default: ;
		endcase
	endfunction

	// sample at the current note position (zeroed first on restart), then advance the position
	function automatic env_sample_t envelope_at(input logic rst);
		env_sample_t s;
		logic [63:0] i, a, d, r, t, prod;
		s.level = '0;
		s.segment = SEG_FINISHED;
		s.last = 1'b0;
		if (rst)
			note_pos = '0;
		i = 64'(note_pos);
		a = 64'(shadow_regs.attack_len);
		d = 64'(shadow_regs.decay_len);
		r = 64'(shadow_regs.release_len);
		t = 64'(shadow_regs.total_len);
		if (i < t) begin
			if (a + d + r >= t) begin
				s.level = FALLBACK_Q23;
				s.segment = SEG_FALLBACK;
			end else if (i < a) begin
				prod = 64'(shadow_regs.attack_step) * i;
				s.level = clamp_one(prod);
				s.segment = SEG_ATTACK;
			end else if (i < a + d) begin
				prod = 64'(shadow_regs.decay_step) * (i - a);
				s.level = (prod >= 64'(ONE_Q23)) ? '0 : DATA_W'(64'(ONE_Q23) - prod);
				s.segment = SEG_DECAY;
			end else if (i < t - r) begin
				s.level = clamp_one(64'(shadow_regs.sustain_level));
				s.segment = SEG_SUSTAIN;
			end else begin
				prod = 64'(shadow_regs.release_step) * (t - i);
				s.level = clamp_one(prod);
				s.segment = SEG_RELEASE;
			end
			s.last = (i == t - 1);
			// saturate instead of wrapping
			if (note_pos != '1)
				note_pos = note_pos + 1'b1;
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		env_sample_t want;
		if (!arst_n) begin
			shadow_regs = '0;
			note_pos = '0;
			pending_samples.delete();
		end else begin
			if (cfg_wen)
				shadow_write(cfg_idx, cfg_wdata);
			if (in_valid && !in_stall)
				pending_samples.push_back(envelope_at(restart));
			if (out_valid && !out_stall) begin
				if (pending_samples.size() == 0) begin
					report_mismatch("result with no request pending", 0, level);
				end else begin
					want = pending_samples.pop_front();
					if (level !== want.level)
						report_mismatch("level", want.level, level);
					if (segment !== want.segment)
						report_mismatch("segment", want.segment, segment);
					if (last !== want.last)
						report_mismatch("last", want.last, last);
				end
			end
		end
		outstanding = pending_samples.size();
	end

endmodule

// ===== tb/sv/linear_adsr_envelope_test.sv =====
// Top of the envelope testbench: clock, reset, register setup and tick requests,
// receiver stalls and the verdict. Depends on ladsr_pkg, ladsr_checker, linear_adsr_envelope.
module linear_adsr_envelope_test;
	import ladsr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD_CYCLES = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic                 restart;
	logic                 out_valid;
	logic                 out_stall;
	logic [DATA_W-1:0]    level;
	logic [SEG_W-1:0]     segment;
	logic                 last;
	int                   errors;
	int                   outstanding;

	bit quiet;
	bit long_hold;
	int ticks_sent;

	linear_adsr_envelope uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.level(level), .segment(segment), .last(last)
	);

	ladsr_checker envelope_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.level(level), .segment(segment), .last(last),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	task automatic load_envelope(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] d,
		input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] t,
		input logic [DATA_W-1:0] sus, input logic [DATA_W-1:0] a_step,
		input logic [DATA_W-1:0] d_step, input logic [DATA_W-1:0] r_step);
		write_reg(REG_ATTACK_LEN, a);
		write_reg(REG_DECAY_LEN, d);
		write_reg(REG_RELEASE_LEN, r);
		write_reg(REG_TOTAL_LEN, t);
		write_reg(REG_SUSTAIN_LEVEL, sus);
		write_reg(REG_ATTACK_STEP, a_step);
		write_reg(REG_DECAY_STEP, d_step);
		write_reg(REG_RELEASE_STEP, r_step);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// offer one tick request and hold it until taken; returns at a falling edge
	task automatic send_tick(input logic rst);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		ticks_sent++;
	endtask

	// stop sending and let every pending result come back
	task automatic wait_drained;
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_step(input int span, input int len);
		if (len == 0 || $urandom_range(0, 3) == 0)
			return DATA_W'($urandom);
		return DATA_W'(span / len);
	endfunction

	task automatic random_note;
		int a, d, r, t, n, sus_i;
		logic [DATA_W-1:0] sus;
		if ($urandom_range(0, 7) == 0) begin
			a = $urandom_range(0, 24'hFFFFFF);
			d = $urandom_range(0, 24'hFFFFFF);
			r = $urandom_range(0, 24'hFFFFFF);
			t = $urandom_range(0, 24'hFFFFFF);
			n = $urandom_range(4, 12);
		end else begin
			a = $urandom_range(0, 10);
			d = $urandom_range(0, 10);
			r = $urandom_range(0, 10);
			t = $urandom_range(0, 45);
			n = t + $urandom_range(1, 6);
		end
		sus = ($urandom_range(0, 5) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, ONE_Q23));
		sus_i = (sus > ONE_Q23) ? int'(ONE_Q23) : int'(sus);
		load_envelope(DATA_W'(a), DATA_W'(d), DATA_W'(r), DATA_W'(t), sus,
			pick_step(int'(ONE_Q23), a), pick_step(int'(ONE_Q23) - sus_i, d),
			pick_step(sus_i, r));
		send_tick($urandom_range(0, 3) != 0);
		for (int k = 1; k < n; k++)
			send_tick($urandom_range(0, 39) == 0);
		wait_drained();
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		quiet = 1'b0;
		long_hold = 1'b0;
		ticks_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero total length: finished from the start
		send_tick(1'b0);
		send_tick(1'b1);
		wait_drained();

		// all four segments with overrange steps and sustain
		load_envelope(2, 2, 2, 8, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_tick(1'b1);
		repeat (9) send_tick(1'b0);
		wait_drained();

		// short note ending in one release sample
		load_envelope(0, 0, 1, 2, ONE_Q23, 0, 0, ONE_Q23);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		wait_drained();

		// longest lengths: constant fallback
		load_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		wait_drained();

		// longest note with no shaped segments: straight to sustain
		load_envelope(0, 0, 0, 24'hFFFFFF, 24'h5A5A5A, 24'hA5A5A5, 0, 0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();

		// long receiver hold-off while requests keep coming: fill up and stall input
		quiet = 1'b1;
		long_hold = 1'b1;
		repeat (6) send_tick(1'b0);
		wait_drained();
		quiet = 1'b0;

		phase = 0;
		while (ticks_sent < 520) begin
			if (phase == 3)
				long_hold = 1'b1;
			if (ticks_sent >= 440)
				quiet = 1'b1;
			random_note();
			phase++;
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
src/ladsr_pkg.sv
src/ladsr_seq.sv
src/ladsr_level.sv
src/linear_adsr_envelope.sv
tb/sv/ladsr_checker.sv
tb/sv/linear_adsr_envelope_test.sv
